// File: hdl/decimal_command_output_latch_assert.svh
// Assertion macros for the decimal command output latch.
`ifndef DECIMAL_COMMAND_OUTPUT_LATCH_ASSERT_SVH
`define DECIMAL_COMMAND_OUTPUT_LATCH_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define DCOL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Next-cycle implication.
`define DCOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define DCOL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DCOL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/dcol_pkg.sv
package dcol_pkg;

    localparam int NUM_OUTPUTS_DEF      = 6;
    localparam int DIGITS_PER_FIELD_DEF = 3;
    localparam int PIN_BITS             = 6;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] RADIX      = 8'd10;

    typedef struct packed {
        logic       done;
        logic [7:0] index;
        logic [7:0] value;
    } t_frame_evt;

    // acc*10 + digit, mod 256; non-digits leave acc as is
    function automatic logic [7:0] acc_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] digit;
        digit = b - ASCII_ZERO;
        if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
            return 8'(acc * RADIX + digit);
        end
        return acc;
    endfunction

endpackage

// File: hdl/dcol_decoder.sv
module dcol_decoder #(
    parameter int DIGITS_PER_FIELD = dcol_pkg::DIGITS_PER_FIELD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output logic                o_at_last,
    output dcol_pkg::t_frame_evt o_evt
);
    import dcol_pkg::*;

    localparam int FRAME_BYTES = 2 * DIGITS_PER_FIELD;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_idx, n_idx;
    logic [7:0]       r_val, n_val;
    logic             w_in_index;
    logic [7:0]       w_idx_upd;
    logic [7:0]       w_val_upd;

    assign o_at_last  = (r_pos == POS_W'(FRAME_BYTES - 1));
    assign w_in_index = (r_pos < POS_W'(DIGITS_PER_FIELD));
    assign w_idx_upd  = w_in_index ? acc_step(r_idx, i_byte) : r_idx;
    assign w_val_upd  = w_in_index ? r_val : acc_step(r_val, i_byte);

    always_comb begin
        o_evt.done  = i_step && o_at_last;
        o_evt.index = w_idx_upd;
        o_evt.value = w_val_upd;
        n_pos = r_pos;
        n_idx = r_idx;
        n_val = r_val;
        if (i_step) begin
            if (o_at_last) begin
                n_pos = '0;
                n_idx = '0;
                n_val = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
                n_idx = w_idx_upd;
                n_val = w_val_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_idx <= '0;
            r_val <= '0;
        end else begin
            r_pos <= n_pos;
            r_idx <= n_idx;
            r_val <= n_val;
        end
    end

endmodule

// File: hdl/dcol_latch_bank.sv
module dcol_latch_bank #(
    parameter int NUM_OUTPUTS = dcol_pkg::NUM_OUTPUTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dcol_pkg::t_frame_evt          i_evt,
    output logic                          o_accepted,
    output logic [dcol_pkg::PIN_BITS-1:0] o_pin_levels
);
    import dcol_pkg::*;

    // only registers that reach a pin are kept
    localparam int PIN_COUNT = (NUM_OUTPUTS < PIN_BITS) ? NUM_OUTPUTS : PIN_BITS;

    logic [7:0] r_latch [PIN_COUNT];
    logic [7:0] n_latch [PIN_COUNT];

    assign o_accepted = (i_evt.index < 8'(NUM_OUTPUTS));

    always_comb begin
        o_pin_levels = '0;
        for (int i = 0; i < PIN_COUNT; i++) begin
            n_latch[i] = r_latch[i];
            if (i_evt.done && o_accepted && i_evt.index == 8'(i)) begin
                n_latch[i] = i_evt.value;
            end
            o_pin_levels[i] = (n_latch[i] != 8'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIN_COUNT; i++) begin
                r_latch[i] <= '0;
            end
        end else begin
            for (int i = 0; i < PIN_COUNT; i++) begin
                r_latch[i] <= n_latch[i];
            end
        end
    end

endmodule

// File: hdl/decimal_command_output_latch.sv
// Decimal command output latch. Bytes arrive in frames of 2*DIGITS_PER_FIELD;
// the first half is a decimal index, the second a decimal value (ASCII digits,
// each giving acc*10+digit mod 256; other bytes hold their slot but are
// skipped). On the last byte of a frame the value is written to output
// register <index> if the index is below NUM_OUTPUTS, and one result item
// goes out with the index, value, accepted flag and the pin levels of
// registers 0..5 after the write. Rate: one byte per cycle unless input
// stalls. A byte passes an input register, then one pass of decode/latch
// logic into the result register. Input only stalls when a frame-end byte
// meets a result register that is still held by the consumer.
`include "decimal_command_output_latch_assert.svh"

module decimal_command_output_latch #(
    parameter int NUM_OUTPUTS      = dcol_pkg::NUM_OUTPUTS_DEF,
    parameter int DIGITS_PER_FIELD = dcol_pkg::DIGITS_PER_FIELD_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_target_index,
    output logic [7:0]                    o_new_value,
    output logic                          o_accepted,
    output logic [dcol_pkg::PIN_BITS-1:0] o_pin_levels
);
    import dcol_pkg::*;

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_out_valid;
    logic [7:0]          r_target_index;
    logic [7:0]          r_new_value;
    logic                r_accepted;
    logic [PIN_BITS-1:0] r_pin_levels;

    logic                w_at_last;
    logic                w_out_free;
    logic                w_step;
    logic                w_load;
    logic                w_accepted;
    logic [PIN_BITS-1:0] w_pins;
    t_frame_evt          w_evt;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && (!w_at_last || w_out_free);
    assign w_load     = w_evt.done;
    assign o_in_ready = !r_in_valid || w_step;

    dcol_decoder #(
        .DIGITS_PER_FIELD(DIGITS_PER_FIELD)
    ) u_decoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .o_at_last(w_at_last),
        .o_evt    (w_evt)
    );

    dcol_latch_bank #(
        .NUM_OUTPUTS(NUM_OUTPUTS)
    ) u_latch_bank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (w_evt),
        .o_accepted  (w_accepted),
        .o_pin_levels(w_pins)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_load) begin
            r_target_index <= w_evt.index;
            r_new_value    <= w_evt.value;
            r_accepted     <= w_accepted;
            r_pin_levels   <= w_pins;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_target_index = r_target_index;
    assign o_new_value    = r_new_value;
    assign o_accepted     = r_accepted;
    assign o_pin_levels   = r_pin_levels;

    `DCOL_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, w_load, w_out_free)
    `DCOL_ASSERT_IMPLY(a_accept_in_range, i_clk, i_rst_n,
        r_out_valid && r_accepted, r_target_index < 8'(NUM_OUTPUTS))
    `DCOL_ASSERT_IMPLY(a_reject_out_of_range, i_clk, i_rst_n,
        r_out_valid && !r_accepted, r_target_index >= 8'(NUM_OUTPUTS))
    `DCOL_ASSERT_IMPLY(a_pin_matches, i_clk, i_rst_n,
        r_out_valid && r_accepted && r_target_index < 8'(PIN_BITS),
        r_pin_levels[r_target_index[2:0]] == (r_new_value != 8'd0))

endmodule

// File: tb/tb_decimal_command_output_latch.sv
module tb_decimal_command_output_latch;
    import dcol_pkg::*;

    localparam int FRAME_LEN  = 2 * DIGITS_PER_FIELD_DEF;
    localparam int IDLE_LIMIT = 500;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        bit [7:0]          index;
        bit [7:0]          value;
        bit                ok;
        bit [PIN_BITS-1:0] pins;
    } t_frame_result;

    class frame_book;
        bit [2:0]      slot;
        bit [7:0]      idx_acc;
        bit [7:0]      val_acc;
        bit [7:0]      regs [NUM_OUTPUTS_DEF];
        t_frame_result pending [$];
        int            mismatches;
        int            frames_seen;
        int            rejected_seen;

        function bit [7:0] fold_digit(bit [7:0] acc, bit [7:0] b);
            bit [7:0] d;
            d = b - ASCII_ZERO;
            if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
                return 8'(acc * RADIX + d);
            end
            return acc;
        endfunction

        function void take_byte(bit [7:0] b);
            t_frame_result r;
            if (slot < DIGITS_PER_FIELD_DEF) begin
                idx_acc = fold_digit(idx_acc, b);
            end else begin
                val_acc = fold_digit(val_acc, b);
            end
            if (int'(slot) + 1 < FRAME_LEN) begin
                slot++;
                return;
            end
            r.ok = idx_acc < NUM_OUTPUTS_DEF;
            if (r.ok) begin
                regs[idx_acc] = val_acc;
            end
            r.index = idx_acc;
            r.value = val_acc;
            r.pins  = '0;
            for (int i = 0; i < NUM_OUTPUTS_DEF && i < PIN_BITS; i++) begin
                r.pins[i] = regs[i] != 0;
            end
            pending.push_back(r);
            slot    = 0;
            idx_acc = 0;
            val_acc = 0;
        endfunction

        task report(string what);
            if (mismatches < MAX_PRINTS) begin
                $display("mismatch: %s", what);
            end
            mismatches++;
        endtask

        task check_frame(t_frame_result got);
            t_frame_result want;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending: index %0d value %0d",
                                 got.index, got.value));
                return;
            end
            want = pending.pop_front();
            frames_seen++;
            if (!want.ok) begin
                rejected_seen++;
            end
            if (got.index != want.index) begin
                report($sformatf("frame %0d index %0d, want %0d",
                                 frames_seen, got.index, want.index));
            end
            if (got.value != want.value) begin
                report($sformatf("frame %0d value %0d, want %0d",
                                 frames_seen, got.value, want.value));
            end
            if (got.ok != want.ok) begin
                report($sformatf("frame %0d accepted %0d, want %0d",
                                 frames_seen, got.ok, want.ok));
            end
            if (got.pins != want.pins) begin
                report($sformatf("frame %0d pins %b, want %b",
                                 frames_seen, got.pins, want.pins));
            end
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [7:0]          i_rx_byte;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [7:0]          o_target_index;
    logic [7:0]          o_new_value;
    logic                o_accepted;
    logic [PIN_BITS-1:0] o_pin_levels;

    frame_book book = new();
    bit        tx_steady;
    int        bytes_sent;
    int        idle_cycles;

    decimal_command_output_latch dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_target_index (o_target_index),
        .o_new_value    (o_new_value),
        .o_accepted     (o_accepted),
        .o_pin_levels   (o_pin_levels)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", IDLE_LIMIT);
                $display("FAIL decimal_command_output_latch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task send_byte(bit [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        book.take_byte(b);
        bytes_sent++;
    endtask

    task send_frame(bit [7:0] f0, bit [7:0] f1, bit [7:0] f2,
                    bit [7:0] f3, bit [7:0] f4, bit [7:0] f5);
        send_byte(f0);
        send_byte(f1);
        send_byte(f2);
        send_byte(f3);
        send_byte(f4);
        send_byte(f5);
    endtask

    task drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending.size() != 0) @(posedge i_clk);
    endtask

    function bit [7:0] rand_digit(int lo, int hi);
        return ASCII_ZERO + 8'($urandom_range(lo, hi));
    endfunction

    // noise hits a byte with the given percent chance
    function bit [7:0] maybe_noise(bit [7:0] b, int pct);
        if ($urandom_range(0, 99) < pct) begin
            return 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    task send_random_frame();
        bit [7:0] fb [FRAME_LEN];
        int       kind;
        int       pct;
        kind = $urandom_range(0, 9);
        pct  = (kind >= 8) ? 30 : 5;
        for (int i = 0; i < FRAME_LEN; i++) begin
            fb[i] = rand_digit(0, 9);
        end
        if (kind <= 6) begin
            fb[0] = ASCII_ZERO;
            fb[1] = ASCII_ZERO;
            fb[2] = rand_digit(0, 7);
            if ($urandom_range(0, 3) == 0) begin
                fb[3] = ASCII_ZERO;
                fb[4] = ASCII_ZERO;
                fb[5] = ASCII_ZERO;
            end
        end
        for (int i = 0; i < FRAME_LEN; i++) begin
            send_byte(maybe_noise(fb[i], pct));
        end
    endtask

    initial begin
        t_frame_result got;
        bit            rx_steady;
        int            stall;
        int            taken;
        i_out_ready <= 1'b0;
        taken = 0;
        rx_steady = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 8 == 0) begin
                rx_steady = $urandom_range(0, 3) == 0;
            end
            stall = rx_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got.index = o_target_index;
            got.value = o_new_value;
            got.ok    = o_accepted;
            got.pins  = o_pin_levels;
            book.check_frame(got);
            taken++;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_rx_byte   <= 8'h00;
        idle_cycles <= 0;
        tx_steady = 0;
        bytes_sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // index 5, value 255
        send_frame("0", "0", "5", "2", "5", "5");
        // non-digits around the digit range and at the byte extremes
        send_frame(8'h2F, 8'h3A, "3", 8'h00, "9", 8'hFF);
        // first out-of-range index, value wraps
        send_frame("0", "0", "6", "9", "9", "9");
        // zero written to register 5 clears its pin
        send_frame("5", 8'h80, 8'h7F, "0", "0", "0");
        drain_results();

        for (int f = 0; f < 75; f++) begin
            if (f % 5 == 0) begin
                tx_steady = $urandom_range(0, 3) == 0;
            end
            if (f == 40) begin
                drain_results();
            end
            send_random_frame();
        end
        i_in_valid <= 1'b0;

        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes; checked %0d frames, %0d with index out of range",
                 bytes_sent, book.frames_seen, book.rejected_seen);
        $display("mismatches: %0d", book.mismatches);
        if (book.mismatches == 0) begin
            $display("PASS decimal_command_output_latch");
        end else begin
            $display("FAIL decimal_command_output_latch");
        end
        $finish;
    end
endmodule
